@@ hdl/dsc_pkg.sv @@
// Shared types and constants of the device sighting cache.
// Holds the item and result structs, the table entry layout, outcome codes,
// controller states and the command/status bundles. Depends on nothing.
package dsc_pkg;

  localparam int SLOT_W     = 6;
  localparam int CFG_ADDR_W = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_STALE_LIMIT = 1'b0;
  localparam logic [31:0] STALE_LIMIT_RESET = 32'd30000;

  localparam logic KIND_OBSERVE = 1'b0;
  localparam logic KIND_COLLECT = 1'b1;

  localparam logic [2:0] OUTCOME_UPDATED  = 3'd0;
  localparam logic [2:0] OUTCOME_FILLED   = 3'd1;
  localparam logic [2:0] OUTCOME_REPLACED = 3'd2;
  localparam logic [2:0] OUTCOME_LISTED   = 3'd3;
  localparam logic [2:0] OUTCOME_NOTHING  = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [31:0]       now_ms;
    logic [47:0]       device_addr;
    logic [7:0]        device_type;
    logic signed [7:0] signal_level;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        outcome;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       entry_addr;
    logic signed [7:0] entry_level;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [47:0]       addr;
    logic [7:0]        dtype;
    logic signed [7:0] level;
    logic [31:0]       seen;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_FINISH
  } dsc_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic write_slot;
    logic finish;
  } dsc_cmd_t;

  typedef struct packed {
    logic collect;
    logic need_push;
    logic out_free;
    logic scan_done;
  } dsc_status_t;

endpackage

@@ hdl/dsc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dsc_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ hdl/dsc_ctrl.sv @@
// Sequencer of the device sighting cache: walks the table slot by slot and
// paces writes and result transfers. Depends on dsc_pkg.
module dsc_ctrl import dsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dsc_status_t status,
  output dsc_cmd_t    cmd
);

  dsc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        // hold while a listed entry waits for the output register
        if (!status.need_push || status.out_free) begin
          cmd.eval = 1'b1;
          if (status.scan_done) begin
            state_nxt = status.collect ? S_FINISH : S_WRITE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.write_slot = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/dsc_datapath.sv @@
// Datapath of the device sighting cache: entry RAM, valid bits, scan
// trackers, pending listed entry and the output register.
// Depends on dsc_pkg and dsc_ram.
module dsc_datapath import dsc_pkg::*; #(
  parameter int TABLE_SLOTS = 16,
  parameter int LIST_LIMIT  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dsc_cmd_t    cmd,
  output dsc_status_t status,
  input  in_item_t    in_data,
  input  logic [31:0] stale_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(LIST_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIST_LIMIT);

  in_item_t               item_r;
  logic [IDX_W-1:0]       idx_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   pend_valid_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic [47:0]            pend_addr_r;
  logic signed [7:0]      pend_level_r;
  logic                   match_found_r;
  logic [IDX_W-1:0]       match_idx_r;
  logic                   empty_found_r;
  logic [IDX_W-1:0]       empty_idx_r;
  logic [31:0]            oldest_t_r;
  logic [IDX_W-1:0]       oldest_idx_r;
  logic [TABLE_SLOTS-1:0] valid_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  entry_t           rd_entry;
  entry_t           wr_entry;
  logic [IDX_W-1:0] wr_idx;
  logic [2:0]       wr_outcome;
  logic             cur_valid;
  logic             key_hit;
  logic [31:0]      age;
  logic             fresh;
  logic             out_free;

  dsc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.write_slot),
    .waddr   (wr_idx),
    .wdata   (wr_entry),
    .raddr   (idx_r),
    .rdata_r (rd_entry)
  );

  assign cur_valid = valid_r[idx_r];
  assign key_hit   = cur_valid && (rd_entry.dtype == item_r.device_type)
                     && (rd_entry.addr == item_r.device_addr);
  assign age       = item_r.now_ms - rd_entry.seen;
  assign fresh     = cur_valid && (age <= stale_limit) && (cnt_r < LIMIT_CNT);
  assign out_free  = !out_valid_r || !out_stall;

  assign status.collect   = (item_r.kind == KIND_COLLECT);
  assign status.need_push = (item_r.kind == KIND_COLLECT) && fresh && pend_valid_r;
  assign status.out_free  = out_free;
  assign status.scan_done = (idx_r == LAST_IDX);

  always_comb begin
    priority if (match_found_r) begin
      wr_idx     = match_idx_r;
      wr_outcome = OUTCOME_UPDATED;
    end else if (empty_found_r) begin
      wr_idx     = empty_idx_r;
      wr_outcome = OUTCOME_FILLED;
    end else begin
      wr_idx     = oldest_idx_r;
      wr_outcome = OUTCOME_REPLACED;
    end
  end

  // a matched entry is rewritten with its own key, so one full-word write serves all cases
  assign wr_entry.addr  = item_r.device_addr;
  assign wr_entry.dtype = item_r.device_type;
  assign wr_entry.level = item_r.signal_level;
  assign wr_entry.seen  = item_r.now_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      pend_valid_r  <= 1'b0;
      match_found_r <= 1'b0;
      empty_found_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        pend_valid_r  <= 1'b0;
        match_found_r <= 1'b0;
        empty_found_r <= 1'b0;
      end
      if (cmd.eval) begin
        if (item_r.kind == KIND_OBSERVE) begin
          if (key_hit && !match_found_r) begin
            match_found_r <= 1'b1;
          end
          if (!cur_valid && !empty_found_r) begin
            empty_found_r <= 1'b1;
          end
        end else if (fresh) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.write_slot) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r       <= in_data;
      idx_r        <= '0;
      cnt_r        <= '0;
      oldest_t_r   <= in_data.now_ms;
      oldest_idx_r <= '0;
    end
    if (cmd.eval) begin
      if (item_r.kind == KIND_OBSERVE) begin
        if (key_hit && !match_found_r) begin
          match_idx_r <= idx_r;
        end
        if (!cur_valid && !empty_found_r) begin
          empty_idx_r <= idx_r;
        end
        if (rd_entry.seen < oldest_t_r) begin
          oldest_t_r   <= rd_entry.seen;
          oldest_idx_r <= idx_r;
        end
      end else if (fresh) begin
        pend_idx_r   <= idx_r;
        pend_addr_r  <= rd_entry.addr;
        pend_level_r <= rd_entry.level;
        cnt_r        <= cnt_r + CNT_W'(1);
      end
      if (idx_r != LAST_IDX) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // output register: a newer listed entry pushes the previous one out with last clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.write_slot || (cmd.eval && status.need_push) || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.write_slot) begin
      out_data_r.outcome     <= wr_outcome;
      out_data_r.slot        <= SLOT_W'(wr_idx);
      out_data_r.entry_addr  <= '0;
      out_data_r.entry_level <= '0;
      out_data_r.last        <= 1'b1;
    end else if ((cmd.eval && status.need_push) || (cmd.finish && pend_valid_r)) begin
      out_data_r.outcome     <= OUTCOME_LISTED;
      out_data_r.slot        <= SLOT_W'(pend_idx_r);
      out_data_r.entry_addr  <= pend_addr_r;
      out_data_r.entry_level <= pend_level_r;
      out_data_r.last        <= cmd.finish;
    end else if (cmd.finish) begin
      out_data_r.outcome     <= OUTCOME_NOTHING;
      out_data_r.slot        <= '0;
      out_data_r.entry_addr  <= '0;
      out_data_r.entry_level <= '0;
      out_data_r.last        <= 1'b1;
    end else begin
      out_data_r <= out_data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/device_sighting_cache.sv @@
// Top level of the device sighting cache: configuration register, sequencer
// and datapath. Depends on dsc_pkg, dsc_ctrl, dsc_datapath and dsc_ram.
//
// A fully associative table of TABLE_SLOTS radio devices keyed by address and
// type byte, held in one RAM with registered read plus a valid bit per slot
// that reset clears. Every item walks the whole table one slot at a time,
// reading a slot and then evaluating it, and the block takes no new item
// until it is through with the last one. A stall on the result side costs
// time only while a result is held in the output register and the walk
// needs to hand over the next one. An observe gives one result; a collect
// gives one result per fresh entry in slot order, at most LIST_LIMIT, or a
// single empty-list result. The stale limit sits at byte address 0 of the
// configuration port; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module device_sighting_cache import dsc_pkg::*; #(
  parameter int TABLE_SLOTS = 16,
  parameter int LIST_LIMIT  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [31:0] stale_limit_r;
  dsc_cmd_t    cmd;
  dsc_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_limit_r <= STALE_LIMIT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_STALE_LIMIT)) begin
      stale_limit_r <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_STALE_LIMIT) ? stale_limit_r : '0;

  dsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dsc_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .LIST_LIMIT  (LIST_LIMIT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_data     (in_data),
    .stale_limit (stale_limit_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  // one item at a time: the block is busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous item still in work");

  // every outcome other than a listed entry closes its item
  a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.outcome == OUTCOME_UPDATED
                   || out_data.outcome == OUTCOME_FILLED
                   || out_data.outcome == OUTCOME_REPLACED
                   || out_data.outcome == OUTCOME_NOTHING)) |-> out_data.last)
    else $error("observe or empty-list result without last");

  // a reported slot always lies inside the table
  a_slot_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.slot < SLOT_W'(TABLE_SLOTS)) || (TABLE_SLOTS == 64))
    else $error("result slot outside the table");

endmodule

@@ test/tb_top.sv @@
// Self-checking bench for device_sighting_cache: directed table, then random
// sighting/collect traffic against an in-bench prediction of the table.
// Depends on dsc_pkg and the device_sighting_cache RTL only.
module tb_top;
  import dsc_pkg::*;

  localparam int TABLE_SLOTS      = 16;
  localparam int LIST_LIMIT       = 16;
  localparam int PAUSE_CYCLES     = 2 * TABLE_SLOTS + 4;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int KEY_POOL         = 24;
  localparam logic [CFG_ADDR_W-1:0] STALE_LIMIT_ADDR = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR   = CFG_ADDR_W'(4);

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // predicted table contents and register
  entry_t      sighting_table [TABLE_SLOTS];
  bit          slot_used [TABLE_SLOTS];
  logic [31:0] stale_limit;

  out_item_t   awaited_reports [$];
  stim_row_t   directed_rows [$];
  logic [47:0] key_addr [KEY_POOL];
  logic [7:0]  key_type [KEY_POOL];
  logic [31:0] now_clock;

  int sender_gap_pct = 0;
  int receiver_stall_pct = 0;
  int stall_left = 0;
  int hold_count = 0;
  bit hold_armed = 1'b0;
  int failures = 0;
  int items_accepted = 0;
  int reports_checked = 0;
  int outcome_tally [5] = '{0, 0, 0, 0, 0};
  out_item_t head;

  device_sighting_cache #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .LIST_LIMIT (LIST_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  function automatic int gap_length(input int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void forecast_reports(input in_item_t it, ref out_item_t reports[$]);
    int          hit;
    int          count;
    int          n;
    logic [31:0] oldest;
    logic [31:0] age;
    bit          listed [TABLE_SLOTS];
    out_item_t   r;
    r = '0;
    if (it.kind == KIND_OBSERVE) begin
      hit = -1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (hit < 0 && slot_used[i] && sighting_table[i].dtype == it.device_type &&
            sighting_table[i].addr == it.device_addr) hit = i;
      end
      if (hit >= 0) begin
        r.outcome = OUTCOME_UPDATED;
        sighting_table[hit].level = it.signal_level;
        sighting_table[hit].seen  = it.now_ms;
      end else begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (hit < 0 && !slot_used[i]) hit = i;
        end
        if (hit >= 0) begin
          r.outcome = OUTCOME_FILLED;
        end else begin
          // evict the smallest timestamp strictly below now, else slot 0
          oldest = it.now_ms;
          hit = 0;
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (sighting_table[i].seen < oldest) begin
              oldest = sighting_table[i].seen;
              hit = i;
            end
          end
          r.outcome = OUTCOME_REPLACED;
        end
        sighting_table[hit].addr  = it.device_addr;
        sighting_table[hit].dtype = it.device_type;
        sighting_table[hit].level = it.signal_level;
        sighting_table[hit].seen  = it.now_ms;
        slot_used[hit] = 1'b1;
      end
      r.slot = SLOT_W'(hit);
      r.last = 1'b1;
      reports.push_back(r);
    end else begin
      count = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        age = it.now_ms - sighting_table[i].seen;
        listed[i] = slot_used[i] && age <= stale_limit && count < LIST_LIMIT;
        if (listed[i]) count++;
      end
      if (count == 0) begin
        r.outcome = OUTCOME_NOTHING;
        r.last = 1'b1;
        reports.push_back(r);
      end else begin
        n = 0;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (listed[i]) begin
            n++;
            r.outcome     = OUTCOME_LISTED;
            r.slot        = SLOT_W'(i);
            r.entry_addr  = sighting_table[i].addr;
            r.entry_level = sighting_table[i].level;
            r.last        = (n == count);
            reports.push_back(r);
          end
        end
      end
    end
  endfunction

  function automatic stim_row_t make_row(input logic kind, input logic [31:0] now,
                                         input logic [47:0] addr, input logic [7:0] dtype,
                                         input logic [7:0] level, input bit typed,
                                         input logic [2:0] outcome, input int slot);
    stim_row_t row;
    row.item.kind         = kind;
    row.item.now_ms       = now;
    row.item.device_addr  = addr;
    row.item.device_type  = dtype;
    row.item.signal_level = level;
    row.typed             = typed;
    row.want              = '0;
    row.want.outcome      = outcome;
    row.want.slot         = SLOT_W'(slot);
    row.want.last         = 1'b1;
    return row;
  endfunction

  // result side: check each transfer, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      reports_checked++;
      if (awaited_reports.size() == 0) begin
        $error("result with nothing pending: outcome %0d slot %0d",
               out_data.outcome, out_data.slot);
        failures++;
      end else begin
        head = awaited_reports.pop_front();
        outcome_tally[head.outcome]++;
        if (out_data.outcome !== head.outcome) begin
          $error("outcome: expected %0d, got %0d", head.outcome, out_data.outcome);
          failures++;
        end
        if (out_data.slot !== head.slot) begin
          $error("slot: expected %0d, got %0d", head.slot, out_data.slot);
          failures++;
        end
        if (out_data.entry_addr !== head.entry_addr) begin
          $error("entry_addr: expected %h, got %h", head.entry_addr, out_data.entry_addr);
          failures++;
        end
        if (out_data.entry_level !== head.entry_level) begin
          $error("entry_level: expected %0d, got %0d", head.entry_level, out_data.entry_level);
          failures++;
        end
        if (out_data.last !== head.last) begin
          $error("last: expected %0d, got %0d", head.last, out_data.last);
          failures++;
        end
      end
    end
    if (hold_armed && hold_count < LONG_HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_left = gap_length(receiver_stall_pct);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t fresh [$];
    gap = gap_length(sender_gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_accepted++;
    forecast_reports(it, fresh);
    if (typed) begin
      awaited_reports.push_back(want);
    end else begin
      foreach (fresh[k]) awaited_reports.push_back(fresh[k]);
    end
  endtask

  // drop valid, wait out every pending result, then let the scan finish
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (PAUSE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr[2] == REG_STALE_LIMIT) stale_limit = value;
  endtask

  task automatic check_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("stale_limit_ms readback: expected %0d, got %0d", want, prdata);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input int count, input int gap_pct, input int stall_pct,
                           input int hold_after);
    in_item_t    it;
    int          pick;
    logic [63:0] wide;
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      if (n == hold_after) hold_armed = 1'b1;
      wide = {$urandom, $urandom};
      it.kind         = ($urandom_range(0, 99) < 30) ? KIND_COLLECT : KIND_OBSERVE;
      it.device_addr  = wide[47:0];
      it.device_type  = 8'($urandom_range(0, 255));
      it.signal_level = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 85) now_clock += $urandom_range(0, 4000);
      else if (pick < 95) now_clock = $urandom;
      else now_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      it.now_ms = now_clock;
      // most sightings reuse a known device so updates and evictions dominate
      if (it.kind == KIND_OBSERVE && $urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, KEY_POOL - 1);
        it.device_addr = key_addr[pick];
        it.device_type = key_type[pick];
      end
      offer_item(it, 1'b0, '0);
    end
    settle();
  endtask

  initial begin
    logic [63:0] wide;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      sighting_table[i] = '0;
      slot_used[i] = 1'b0;
    end
    stale_limit = STALE_LIMIT_RESET;

    directed_rows.push_back(make_row(KIND_COLLECT, 32'd0, '0, '0, '0,
                                     1'b1, OUTCOME_NOTHING, 0));
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'd0, '0, 8'h00, 8'h80,
                                     1'b1, OUTCOME_FILLED, 0));
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF,
                                     8'h7F, 1'b1, OUTCOME_FILLED, 1));
    // same address, other type byte: a separate device
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'd100, '0, 8'h01, 8'h00,
                                     1'b1, OUTCOME_FILLED, 2));
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'd200, '0, 8'h00, 8'h05,
                                     1'b1, OUTCOME_UPDATED, 0));
    // age across the counter wrap
    directed_rows.push_back(make_row(KIND_COLLECT, 32'd300, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF,
                                     1'b0, OUTCOME_NOTHING, 0));
    for (int k = 3; k < TABLE_SLOTS; k++) begin
      directed_rows.push_back(make_row(KIND_OBSERVE, 32'd1000 + 10 * k,
                                       48'hA5A5_5A5A_C3C3 ^ 48'(k), 8'(k), 8'(9 * k - 60),
                                       1'b1, OUTCOME_FILLED, k));
    end
    directed_rows.push_back(make_row(KIND_COLLECT, 32'd2000, '0, '0, '0,
                                     1'b0, OUTCOME_NOTHING, 0));
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'd5000, 48'h0000_0000_0001, 8'h00, 8'hC0,
                                     1'b0, OUTCOME_NOTHING, 0));
    // full table with no timestamp below now: slot 0 goes
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'd0, 48'h8000_0000_0000, 8'h80, 8'h01,
                                     1'b1, OUTCOME_REPLACED, 0));
    directed_rows.push_back(make_row(KIND_COLLECT, 32'h8000_0000, '0, '0, '0,
                                     1'b1, OUTCOME_NOTHING, 0));
    directed_rows.push_back(make_row(KIND_OBSERVE, 32'h8000_0000, 48'hFFFF_FFFF_FFFF, 8'hFF,
                                     8'hFF, 1'b1, OUTCOME_UPDATED, 1));
    directed_rows.push_back(make_row(KIND_COLLECT, 32'h8000_0000, '0, '0, '0,
                                     1'b0, OUTCOME_NOTHING, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    check_register(STALE_LIMIT_ADDR, STALE_LIMIT_RESET);

    sender_gap_pct     = 25;
    receiver_stall_pct = 25;
    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
    end
    settle();

    // some pool devices share an address and differ only in type byte
    for (int k = 0; k < KEY_POOL; k++) begin
      wide = {$urandom, $urandom};
      if (k > 0 && $urandom_range(0, 3) == 0) begin
        key_addr[k] = key_addr[k-1];
        key_type[k] = key_type[k-1] + 8'd1;
      end else begin
        key_addr[k] = wide[47:0];
        key_type[k] = 8'($urandom_range(0, 255));
      end
    end
    now_clock = 32'd10000;

    run_phase(100, 30, 30, -1);
    write_reg(STALE_LIMIT_ADDR, 32'd0);
    // no register behind this address; the stale limit must hold
    write_reg(SPARE_REG_ADDR, $urandom);
    check_register(STALE_LIMIT_ADDR, stale_limit);
    run_phase(100, 0, 0, -1);
    write_reg(STALE_LIMIT_ADDR, 32'hFFFF_FFFF);
    check_register(STALE_LIMIT_ADDR, stale_limit);
    run_phase(100, 50, 50, 10);
    write_reg(STALE_LIMIT_ADDR, $urandom_range(2000, 20000));
    check_register(STALE_LIMIT_ADDR, stale_limit);
    run_phase(95, 20, 60, -1);

    $display("Run covered %0d accepted items and %0d results under four stale limits.",
             items_accepted, reports_checked);
    $display("Outcomes: %0d updated, %0d filled, %0d replaced, %0d listed, %0d empty lists.",
             outcome_tally[OUTCOME_UPDATED], outcome_tally[OUTCOME_FILLED],
             outcome_tally[OUTCOME_REPLACED], outcome_tally[OUTCOME_LISTED],
             outcome_tally[OUTCOME_NOTHING]);
    if (failures == 0 && awaited_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ device_sighting_cache.f @@
hdl/dsc_pkg.sv
hdl/dsc_ram.sv
hdl/dsc_ctrl.sv
hdl/dsc_datapath.sv
hdl/device_sighting_cache.sv
test/tb_top.sv
